// ----- hdl/sstf_pkg.sv -----
// Package for the SSTF disk scheduler: sizes and the controller/datapath
// command and status structs. No dependencies.
package sstf_pkg;

  localparam int MAX_REQ = 64;
  localparam int CYL_W   = 16;
  localparam int SUM_W   = 22;
  localparam int IDX_W   = $clog2(MAX_REQ);
  localparam int CNT_W   = $clog2(MAX_REQ + 1);

  typedef struct packed {
    logic store;   // write accepted request into the store
    logic start;   // load head from start_head, clear sum and served count
    logic scan;    // issue one store read for the nearest-request search
    logic commit;  // take the best candidate as the served request
    logic clear;   // drop the request count after the batch
  } dp_cmd_t;

  typedef struct packed {
    logic empty;      // no request stored
    logic scan_end;   // the read being issued is the last stored entry
    logic last_done;  // the result in the output register closes the batch
  } dp_sts_t;

endpackage

// ----- hdl/sstf_if.sv -----
// Handshake channel interfaces of the SSTF disk scheduler.
// Depends on sstf_pkg for field widths.
interface sstf_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [sstf_pkg::CYL_W-1:0] start_head;

  modport source (output valid, output start_head, input ready);
  modport sink   (input valid, input start_head, output ready);
endinterface

interface sstf_req_if;
  logic                      valid;
  logic                      ready;
  logic [sstf_pkg::CYL_W-1:0] req_cylinder;
  logic                      batch_last;

  modport source (output valid, output req_cylinder, output batch_last, input ready);
  modport sink   (input valid, input req_cylinder, input batch_last, output ready);
endinterface

interface sstf_res_if;
  logic                      valid;
  logic                      ready;
  logic [sstf_pkg::CYL_W-1:0] served_cylinder;
  logic [sstf_pkg::CYL_W-1:0] move_distance;
  logic [sstf_pkg::SUM_W-1:0] total_seek;
  logic                      out_last;

  modport source (output valid, output served_cylinder, output move_distance,
                  output total_seek, output out_last, input ready);
  modport sink   (input valid, input served_cylinder, input move_distance,
                  input total_seek, input out_last, output ready);
endinterface

// ----- hdl/sstf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sstf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/sstf_dp.sv -----
// Datapath of the SSTF disk scheduler: request store, served marks, head,
// running sum, nearest-request search and output registers.
// Depends on sstf_pkg and sstf_ram.
module sstf_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  sstf_pkg::dp_cmd_t        cmd,
  output sstf_pkg::dp_sts_t        sts,
  input  logic                     cfg_we,
  input  logic [sstf_pkg::CYL_W-1:0] cfg_start_head,
  input  logic [sstf_pkg::CYL_W-1:0] req_cylinder,
  output logic [sstf_pkg::CYL_W-1:0] served_cylinder,
  output logic [sstf_pkg::CYL_W-1:0] move_distance,
  output logic [sstf_pkg::SUM_W-1:0] total_seek,
  output logic                     out_last
);

  logic [sstf_pkg::CYL_W-1:0]   start_head;
  logic [sstf_pkg::CNT_W-1:0]   count;
  logic [sstf_pkg::CYL_W-1:0]   head;
  logic [sstf_pkg::SUM_W-1:0]   sum;
  logic [sstf_pkg::CNT_W-1:0]   served;
  logic [sstf_pkg::IDX_W-1:0]   scan_idx;
  logic                         rd_valid;
  logic [sstf_pkg::IDX_W-1:0]   rd_idx;
  logic [sstf_pkg::CYL_W:0]     rdata;
  logic                         found;
  logic [sstf_pkg::CYL_W-1:0]   best_d;
  logic [sstf_pkg::CYL_W-1:0]   best_cyl;
  logic [sstf_pkg::IDX_W-1:0]   best_idx;

  logic                         full;
  logic                         store_we;
  logic                         ram_we;
  logic [sstf_pkg::IDX_W-1:0]   waddr;
  logic [sstf_pkg::CYL_W:0]     wdata;
  logic [sstf_pkg::CYL_W-1:0]   rd_cyl;
  logic [sstf_pkg::CYL_W-1:0]   span;
  logic                         better;
  logic [sstf_pkg::SUM_W:0]     sum_wide;
  logic [sstf_pkg::SUM_W-1:0]   sum_next;

  assign full     = (count == sstf_pkg::CNT_W'(sstf_pkg::MAX_REQ));
  assign store_we = cmd.store && !full;

  // store word: served mark on top, cylinder below; loading clears the mark
  assign ram_we = store_we || cmd.commit;
  assign waddr  = cmd.commit ? best_idx : count[sstf_pkg::IDX_W-1:0];
  assign wdata  = cmd.commit ? {1'b1, best_cyl} : {1'b0, req_cylinder};

  sstf_ram #(
    .WIDTH(sstf_pkg::CYL_W + 1),
    .DEPTH(sstf_pkg::MAX_REQ)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(scan_idx),
    .rdata(rdata)
  );

  assign rd_cyl = rdata[sstf_pkg::CYL_W-1:0];
  assign span   = (rd_cyl >= head) ? (rd_cyl - head) : (head - rd_cyl);
  assign better = rd_valid && !rdata[sstf_pkg::CYL_W] && (!found || (span < best_d));

  assign sum_wide = {1'b0, sum} + (sstf_pkg::SUM_W + 1)'(best_d);
  assign sum_next = sum_wide[sstf_pkg::SUM_W] ? '1 : sum_wide[sstf_pkg::SUM_W-1:0];

  assign sts = '{
    empty:     (count == '0),
    scan_end:  ({1'b0, scan_idx} == (count - sstf_pkg::CNT_W'(1))),
    last_done: out_last
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      start_head <= '0;
    end else if (cfg_we) begin
      start_head <= cfg_start_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      head     <= '0;
      sum      <= '0;
      served   <= '0;
      scan_idx <= '0;
      rd_valid <= 1'b0;
      found    <= 1'b0;
    end else begin
      rd_valid <= cmd.scan;
      if (store_we) begin
        count <= count + sstf_pkg::CNT_W'(1);
      end
      if (cmd.start) begin
        head     <= start_head;
        sum      <= '0;
        served   <= '0;
        scan_idx <= '0;
        found    <= 1'b0;
      end else if (cmd.scan) begin
        scan_idx <= scan_idx + sstf_pkg::IDX_W'(1);
      end else if (cmd.commit) begin
        head     <= best_cyl;
        sum      <= sum_next;
        served   <= served + sstf_pkg::CNT_W'(1);
        scan_idx <= '0;
        found    <= 1'b0;
      end
      if (better) begin
        found <= 1'b1;
      end
      if (cmd.clear) begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (better) begin
      best_d   <= span;
      best_cyl <= rd_cyl;
      best_idx <= rd_idx;
    end
    if (cmd.commit) begin
      served_cylinder <= best_cyl;
      move_distance   <= best_d;
      total_seek      <= sum_next;
      out_last        <= ((served + sstf_pkg::CNT_W'(1)) == count);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sstf_pkg::CNT_W'(sstf_pkg::MAX_REQ))
    else $error("request count beyond store capacity");

  a_commit_found: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> found)
    else $error("commit without a candidate request");

  a_commit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> ({1'b0, best_idx} < count))
    else $error("served request outside the loaded batch");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (count == '0))
    else $error("batch state not cleared");
`endif

endmodule

// ----- hdl/sstf_ctrl.sv -----
// Controller state machine of the SSTF disk scheduler: load, scan, commit
// and emit sequencing. Depends on sstf_pkg.
module sstf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_last,
  output logic              req_ready,
  output logic              res_valid,
  input  logic              res_ready,
  input  sstf_pkg::dp_sts_t sts,
  output sstf_pkg::dp_cmd_t cmd
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      S_LOAD: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.store = 1'b1;
          if (req_last) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        if (sts.empty) begin
          cmd.clear  = 1'b1;
          state_next = S_LOAD;
        end else begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (sts.last_done) begin
            cmd.clear  = 1'b1;
            state_next = S_LOAD;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && res_valid))
    else $error("loading and emitting at once");

  a_last_to_start: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_last) |=> (state == S_START))
    else $error("last request did not start scheduling");

  a_commit_then_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> res_valid)
    else $error("committed result not offered");
`endif

endmodule

// ----- hdl/sstf_disk_scheduler.sv -----
// Top level of the SSTF disk scheduler: channel interfaces, controller and
// datapath. Depends on sstf_pkg, sstf_if, sstf_ctrl, sstf_dp, sstf_ram.
//
//   channel  dir  payload                                            accept
//   cfg      in   start_head[15:0]                                   valid & ready
//   req      in   req_cylinder[15:0], batch_last                     valid & ready
//   res      out  served_cylinder, move_distance, total_seek, last   valid & ready
//
// Requests are loaded while req is ready; a batch then needs a start step, and
// each result needs a read of every stored entry, a read drain, a commit and
// an offer that stretches for as long as res is stalled.
// cfg is always ready; req is ready only while loading, res valid only per result.
// Synchronous reset empties the store and sets start_head to zero.
module sstf_disk_scheduler (
  input  logic       clk,
  input  logic       rst,
  sstf_cfg_if.sink   cfg,
  sstf_req_if.sink   req,
  sstf_res_if.source res
);

  sstf_pkg::dp_cmd_t cmd;
  sstf_pkg::dp_sts_t sts;

  assign cfg.ready = 1'b1;

  sstf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_last (req.batch_last),
    .req_ready(req.ready),
    .res_valid(res.valid),
    .res_ready(res.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sstf_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg.valid),
    .cfg_start_head (cfg.start_head),
    .req_cylinder   (req.req_cylinder),
    .served_cylinder(res.served_cylinder),
    .move_distance  (res.move_distance),
    .total_seek     (res.total_seek),
    .out_last       (res.out_last)
  );

endmodule
